// ----- rtl/core/fcfs_pkg.sv -----
// shared types, widths and codes for the fcfs scheduling metrics block
package fcfs_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int ID_W          = 8;
  localparam int TIME_W        = 16;
  localparam int CLK_W         = 21;
  localparam int SPAN_W        = 20;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } entry_t;

  typedef enum logic [1:0] {
    OP_GT,
    OP_MAX,
    OP_ADD,
    OP_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [CLK_W-1:0] a;
    logic [CLK_W-1:0] b;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_KEY_RD,
    S_KEY_WT,
    S_CMP,
    S_PLACE,
    S_E_RD,
    S_E_WT,
    S_E_MAX,
    S_E_ADD,
    S_E_TURN,
    S_E_WAIT,
    S_OUT
  } state_e;

endpackage

// ----- rtl/core/fcfs_schedule_metrics.sv -----
// top level: batch loading, stable insertion sort and fcfs metric sequencer
//
// Processes are loaded one word per cycle into a 16-entry table; the word with
// batch_end set closes the batch (words past a full table are dropped, but a
// closing word still closes). The table is then insertion-sorted by arrival
// through a memory with one write port and a registered read port: each entry is
// fetched as key, every earlier entry with a later arrival is moved up past it,
// and then the key is written into the place that is left free.
// Each result is then worked out in steps on the shared arithmetic unit (fetch,
// clock catch-up, completion, turnaround, waiting) and is held until taken.
// No input word is taken from closing until the last result has been taken.
module fcfs_schedule_metrics
  import fcfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ID_W-1:0]     process_id_i,
  input  logic [TIME_W-1:0]   arrival_time_i,
  input  logic [TIME_W-1:0]   burst_time_i,
  input  logic                batch_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ID_W-1:0]     out_process_id_o,
  output logic [TIME_W-1:0]   out_arrival_o,
  output logic [TIME_W-1:0]   out_burst_o,
  output logic [CLK_W-1:0]    completion_time_o,
  output logic [SPAN_W-1:0]   turnaround_time_o,
  output logic [SPAN_W-1:0]   waiting_time_o,
  output logic                last_result_o
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    i_q;
  logic [IDX_W-1:0]    j_q;
  logic [CNT_W-1:0]    k_q;
  logic [CLK_W-1:0]    clk_q;
  entry_t              key_q;
  entry_t              cur_q;
  logic [SPAN_W-1:0]   turn_q;
  logic [SPAN_W-1:0]   wait_q;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;
  logic [IDX_W-1:0]    raddr;
  entry_t              rdata;
  alu_req_t            alu_req;
  logic [CLK_W-1:0]    alu_res;

  logic                in_fire;
  logic                room;
  logic                out_fire;
  logic                is_last;
  logic                gt;

  assign in_fire  = in_valid_i && (state_q == S_LOAD);
  assign room     = (count_q < CNT_W'(MAX_PROCESSES));
  assign out_fire = (state_q == S_OUT) && !out_stall_i;
  assign is_last  = ((k_q + CNT_W'(1)) == count_q);
  assign gt       = alu_res[0];

  fcfs_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fcfs_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_fire && batch_end_i) begin
          state_d = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        if (i_q >= count_q) begin
          state_d = S_E_RD;
        end else begin
          state_d = S_KEY_WT;
        end
      end
      S_KEY_WT: state_d = S_CMP;
      S_CMP: begin
        if (!gt) begin
          state_d = S_KEY_RD;
        end else if (j_q == IDX_W'(1)) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE:  state_d = S_KEY_RD;
      S_E_RD:   state_d = S_E_WT;
      S_E_WT:   state_d = S_E_MAX;
      S_E_MAX:  state_d = S_E_ADD;
      S_E_ADD:  state_d = S_E_TURN;
      S_E_TURN: state_d = S_E_WAIT;
      S_E_WAIT: state_d = S_OUT;
      S_OUT: begin
        if (out_fire) begin
          state_d = is_last ? S_LOAD : S_E_RD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // memory and arithmetic unit control
  always_comb begin
    we          = 1'b0;
    waddr       = j_q;
    wdata       = key_q;
    raddr       = i_q[IDX_W-1:0];
    alu_req.op  = OP_GT;
    alu_req.a   = CLK_W'(rdata.arrival);
    alu_req.b   = CLK_W'(key_q.arrival);
    case (state_q)
      S_LOAD: begin
        we          = in_fire && room;
        waddr       = count_q[IDX_W-1:0];
        wdata.id      = process_id_i;
        wdata.arrival = arrival_time_i;
        wdata.burst   = burst_time_i;
      end
      S_KEY_RD: raddr = i_q[IDX_W-1:0];
      S_KEY_WT: raddr = i_q[IDX_W-1:0] - IDX_W'(1);
      S_CMP: begin
        we    = 1'b1;
        wdata = gt ? rdata : key_q;
        raddr = j_q - IDX_W'(2);
      end
      S_PLACE: we = 1'b1;
      S_E_RD:  raddr = k_q[IDX_W-1:0];
      S_E_MAX: begin
        alu_req.op = OP_MAX;
        alu_req.a  = clk_q;
        alu_req.b  = CLK_W'(cur_q.arrival);
      end
      S_E_ADD: begin
        alu_req.op = OP_ADD;
        alu_req.a  = clk_q;
        alu_req.b  = CLK_W'(cur_q.burst);
      end
      S_E_TURN: begin
        alu_req.op = OP_SUB;
        alu_req.a  = clk_q;
        alu_req.b  = CLK_W'(cur_q.arrival);
      end
      S_E_WAIT: begin
        alu_req.op = OP_SUB;
        alu_req.a  = CLK_W'(turn_q);
        alu_req.b  = CLK_W'(cur_q.burst);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      clk_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_fire && room) begin
            count_q <= count_q + CNT_W'(1);
          end
          if (in_fire && batch_end_i) begin
            i_q <= CNT_W'(1);
            k_q <= '0;
            clk_q <= '0;
          end
        end
        S_KEY_WT: j_q <= i_q[IDX_W-1:0];
        S_CMP: begin
          if (gt) begin
            j_q <= j_q - IDX_W'(1);
          end else begin
            i_q <= i_q + CNT_W'(1);
          end
        end
        S_PLACE: i_q <= i_q + CNT_W'(1);
        S_E_MAX: clk_q <= alu_res;
        S_E_ADD: clk_q <= alu_res;
        S_OUT: begin
          if (out_fire) begin
            k_q <= k_q + CNT_W'(1);
            if (is_last) begin
              count_q <= '0;
              clk_q   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_KEY_WT: key_q  <= rdata;
      S_E_WT:   cur_q  <= rdata;
      S_E_TURN: turn_q <= alu_res[SPAN_W-1:0];
      S_E_WAIT: wait_q <= alu_res[SPAN_W-1:0];
      default: ;
    endcase
  end

  // handshake and result word
  always_comb begin
    in_stall_o  = (state_q != S_LOAD);
    out_valid_o = (state_q == S_OUT);
  end

  assign out_process_id_o  = cur_q.id;
  assign out_arrival_o     = cur_q.arrival;
  assign out_burst_o       = cur_q.burst;
  assign completion_time_o = clk_q;
  assign turnaround_time_o = turn_q;
  assign waiting_time_o    = wait_q;
  assign last_result_o     = is_last;

endmodule

// ----- rtl/core/fcfs_table.sv -----
// process table memory, one write port and one registered read port
module fcfs_table
  import fcfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [MAX_PROCESSES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fcfs_alu.sv -----
// shared compare, max, add and subtract unit on run clock width
module fcfs_alu
  import fcfs_pkg::*;
(
  input  alu_req_t         req_i,
  output logic [CLK_W-1:0] res_o
);

  always_comb begin
    case (req_i.op)
      OP_GT:   res_o = {{(CLK_W-1){1'b0}}, (req_i.a > req_i.b)};
      OP_MAX:  res_o = (req_i.a > req_i.b) ? req_i.a : req_i.b;
      OP_ADD:  res_o = req_i.a + req_i.b;
      OP_SUB:  res_o = req_i.a - req_i.b;
      default: res_o = '0;
    endcase
  end

endmodule
